[sv/structured_grid_entity_indexer_unit_macros.svh]
// Assertion macros used by the indexer checker.
`ifndef STRUCTURED_GRID_ENTITY_INDEXER_UNIT_MACROS_SVH
`define STRUCTURED_GRID_ENTITY_INDEXER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGEI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SGEI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sgei_pkg.sv]
// Shared types, codes and the divider step function of the grid indexer.
package sgei_pkg;

  localparam int MAX_AXIS_LEN_DEF = 1024;
  localparam int NUMBER_WIDTH_DEF = 32;

  // Restoring divide: 32 quotient bits, four bits per pipeline stage.
  localparam int DIV_BITS   = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

  // Request kinds.
  localparam logic [2:0] KIND_NODE_POS = 3'd0;
  localparam logic [2:0] KIND_CELL_POS = 3'd1;
  localparam logic [2:0] KIND_EDGE_POS = 3'd2;
  localparam logic [2:0] KIND_FACE_POS = 3'd3;
  localparam logic [2:0] KIND_EDGE_NUM = 3'd4;
  localparam logic [2:0] KIND_FACE_NUM = 3'd5;

  // Axis codes.
  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_I    = 2'd1;
  localparam logic [1:0] AXIS_J    = 2'd2;
  localparam logic [1:0] AXIS_K    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_I_LEN      = 2'd0;
  localparam logic [1:0] CFG_J_LEN      = 2'd1;
  localparam logic [1:0] CFG_K_LEN      = 2'd2;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AXIS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] entity_number;
    logic [1:0]  axis_in;
    logic [9:0]  pos_i;
    logic [9:0]  pos_j;
    logic [9:0]  pos_k;
  } in_item_t;

  typedef struct packed {
    logic [31:0] number_out;
    logic [1:0]  axis_out;
    logic [9:0]  i_out;
    logic [9:0]  j_out;
    logic [9:0]  k_out;
    logic [1:0]  status;
  } out_item_t;

  // State carried through the divider stages.
  typedef struct packed {
    logic        is_pos;
    logic [1:0]  st;
    logic [1:0]  ax;
    logic [31:0] nb;
    logic [10:0] ex;
    logic [10:0] ey;
    logic [31:0] x;
    logic [11:0] rem;
    logic [9:0]  r0;
  } div_t;

  function automatic div_t div_steps(div_t s, logic [10:0] d);
    logic [11:0] t;
    div_t r;
    r = s;
    for (int b = 0; b < DIV_STEP; b++) begin
      t = {r.rem[10:0], r.x[31]};
      r.x = {r.x[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem  = t - {1'b0, d};
        r.x[0] = 1'b1;
      end else begin
        r.rem = t;
      end
    end
    return r;
  endfunction

endpackage

[sv/structured_grid_entity_indexer_unit.sv]
// Structured grid entity indexer: entity number <-> (axis, i, j, k) mapping pipeline.
//
// Takes one request per cycle while in_ready is high and returns one result per
// request, in order, through the request register, the decode stage, the divide
// stages and the output register. Depth is set by the two chained 32-bit
// restoring divides (number by i extent, then quotient by j extent), four
// quotient bits per stage, eight stages each. Every stage has its own valid bit
// and stalls only when the stage ahead is full and held, so bubbles collapse and
// a waiting result does not block new requests until the pipeline fills. Grid
// extents, edge and face counts are derived from the configuration registers
// in a three-stage chain; after a configuration write (and after reset) in_ready
// is held low by a settle counter while that chain settles. cfg_ready is always
// high.
module structured_grid_entity_indexer_unit #(
  parameter int MAX_AXIS_LEN = sgei_pkg::MAX_AXIS_LEN_DEF,
  parameter int NUMBER_WIDTH = sgei_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgei_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sgei_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int DIV_TOTAL = 2 * sgei_pkg::DIV_STAGES;
  localparam int DV0       = 2;                 // stage index of the first divide stage
  localparam int NST       = DV0 + DIV_TOTAL + 1;
  localparam logic [31:0] NB_MASK =
    (NUMBER_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << NUMBER_WIDTH) - 64'd1);
  localparam logic [1:0] SETTLE = 2'd3;

  // Configuration registers.
  logic [10:0] i_len_r, j_len_r, k_len_r;
  logic [30:0] node_count_r;
  logic [1:0]  settle_r;

  function automatic logic [10:0] clamp_len(logic [10:0] v);
    logic [10:0] r;
    r = v;
    if (32'(v) > MAX_AXIS_LEN) r = 11'(MAX_AXIS_LEN);
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_len_r      <= '0;
      j_len_r      <= '0;
      k_len_r      <= '0;
      node_count_r <= '0;
      settle_r     <= SETTLE;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sgei_pkg::CFG_I_LEN:      i_len_r      <= clamp_len(cfg_data[10:0]);
          sgei_pkg::CFG_J_LEN:      j_len_r      <= clamp_len(cfg_data[10:0]);
          sgei_pkg::CFG_K_LEN:      k_len_r      <= clamp_len(cfg_data[10:0]);
          sgei_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data[30:0];
          default: ;
        endcase
        settle_r <= SETTLE;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Derived extents, first layer: cell extents and pairwise products.
  logic [10:0] ci_r, cj_r, ck_r, j1_r, k1_r, cjx_r, ckx_r;
  logic [21:0] p_cij_r, p_icj_r, p_cc_r, p_c1c_r, p_cc1_r, p_ij_r, p_cell_r;

  always_ff @(posedge clk) begin
    logic [10:0] ci, cj, ck;
    ci = (i_len_r == 11'd0) ? 11'd0 : i_len_r - 11'd1;
    cj = (j_len_r == 11'd0) ? 11'd0 : j_len_r - 11'd1;
    ck = (k_len_r == 11'd0) ? 11'd0 : k_len_r - 11'd1;
    ci_r     <= ci;
    cj_r     <= cj;
    ck_r     <= ck;
    j1_r     <= (j_len_r == 11'd0) ? 11'd1 : j_len_r;
    k1_r     <= (k_len_r == 11'd0) ? 11'd1 : k_len_r;
    cjx_r    <= (j_len_r == 11'd0) ? 11'd1 : cj;
    ckx_r    <= (k_len_r == 11'd0) ? 11'd1 : ck;
    p_cij_r  <= ci * j_len_r;
    p_icj_r  <= i_len_r * cj;
    p_cc_r   <= ci * cj;
    p_c1c_r  <= 22'(({1'b0, ci} + 12'd1) * cj);
    p_cc1_r  <= 22'(ci * ({1'b0, cj} + 12'd1));
    p_ij_r   <= i_len_r * j_len_r;
    p_cell_r <= ci * ((j_len_r == 11'd0) ? 11'd1 : cj);
  end

  // Second layer: per-axis edge and face counts, cell count.
  logic [35:0] cell_cnt_r, e1_r, e2_r, e3_r, f1_r, f2_r, f3_r;

  always_ff @(posedge clk) begin
    cell_cnt_r <= 36'(p_cell_r * ckx_r);
    e1_r       <= 36'(p_cij_r * k1_r);
    e2_r       <= 36'(p_icj_r * k1_r);
    e3_r       <= 36'(p_ij_r * ck_r);
    f1_r       <= 36'(p_c1c_r * ck_r);
    f2_r       <= 36'(p_cc1_r * ck_r);
    f3_r       <= 36'(p_cc_r * ({1'b0, ck_r} + 12'd1));
  end

  // Third layer: running totals for the axis walk.
  logic [35:0] ecum2_r, ecum3_r, fcum2_r, fcum3_r;

  always_ff @(posedge clk) begin
    ecum2_r <= e1_r + e2_r;
    ecum3_r <= e1_r + e2_r + e3_r;
    fcum2_r <= f1_r + f2_r;
    fcum3_r <= f1_r + f2_r + f3_r;
  end

  // Stage handshake: a stage advances when empty or when the one ahead advances.
  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = out_ready;
    for (int s = NST - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ready  = en[0] && (settle_r == 2'd0);
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid && (settle_r == 2'd0);
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // Stage 0: capture the request.
  sgei_pkg::in_item_t in_r;

  always_ff @(posedge clk) begin
    if (en[0]) in_r <= in_data;
  end

  // Stage 1: decode kind, walk the axis blocks, form the number-op products.
  typedef struct packed {
    logic        is_pos;
    logic [1:0]  st;
    logic [1:0]  ax;
    logic [31:0] n0;
    logic [10:0] ex;
    logic [10:0] ey;
    logic [20:0] m1;
    logic [32:0] m2;
    logic [35:0] off;
    logic [9:0]  pi;
  } dec_t;

  dec_t dec_nxt, dec_r;

  always_comb begin
    logic [35:0] t;
    logic [10:0] ei;
    logic [22:0] eij;
    logic        cell_bad;
    t        = {4'd0, in_r.entity_number};
    ei       = 11'd0;
    eij      = 23'd0;
    cell_bad = (in_r.entity_number == 32'd0) || (t > cell_cnt_r);
    dec_nxt        = '0;
    dec_nxt.is_pos = 1'b1;
    dec_nxt.st     = sgei_pkg::ST_OK;
    dec_nxt.ax     = sgei_pkg::AXIS_NONE;
    dec_nxt.ex     = 11'd1;
    dec_nxt.ey     = 11'd1;
    dec_nxt.pi     = in_r.pos_i;
    case (in_r.kind)
      sgei_pkg::KIND_NODE_POS: begin
        if (in_r.entity_number == 32'd0 || in_r.entity_number > {1'b0, node_count_r}) begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end else if (i_len_r == 11'd0) begin
          dec_nxt.st = sgei_pkg::ST_NONE;
        end else begin
          dec_nxt.n0 = in_r.entity_number - 32'd1;
          dec_nxt.ex = i_len_r;
          dec_nxt.ey = j1_r;
        end
      end
      sgei_pkg::KIND_CELL_POS: begin
        if (cell_bad) begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end else begin
          dec_nxt.n0 = in_r.entity_number - 32'd1;
          dec_nxt.ex = ci_r;
          dec_nxt.ey = cjx_r;
        end
      end
      sgei_pkg::KIND_EDGE_POS: begin
        if (j_len_r == 11'd0) begin
          dec_nxt.st = sgei_pkg::ST_NONE;
        end else if (in_r.entity_number == 32'd0) begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end else if (t <= e1_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_I;
          dec_nxt.n0 = 32'(t - 36'd1);
          dec_nxt.ex = ci_r;
          dec_nxt.ey = j_len_r;
        end else if (t <= ecum2_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_J;
          dec_nxt.n0 = 32'(t - 36'd1 - e1_r);
          dec_nxt.ex = i_len_r;
          dec_nxt.ey = cj_r;
        end else if (t <= ecum3_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_K;
          dec_nxt.n0 = 32'(t - 36'd1 - ecum2_r);
          dec_nxt.ex = i_len_r;
          dec_nxt.ey = j_len_r;
        end else begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end
      end
      sgei_pkg::KIND_FACE_POS: begin
        if (k_len_r == 11'd0) begin
          // flat grid: a face is a cell, reported along i
          if (cell_bad) begin
            dec_nxt.st = sgei_pkg::ST_RANGE;
          end else begin
            dec_nxt.ax = sgei_pkg::AXIS_I;
            dec_nxt.n0 = in_r.entity_number - 32'd1;
            dec_nxt.ex = ci_r;
            dec_nxt.ey = cjx_r;
          end
        end else if (in_r.entity_number == 32'd0) begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end else if (t <= f1_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_I;
          dec_nxt.n0 = 32'(t - 36'd1);
          dec_nxt.ex = ci_r + 11'd1;
          dec_nxt.ey = cj_r;
        end else if (t <= fcum2_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_J;
          dec_nxt.n0 = 32'(t - 36'd1 - f1_r);
          dec_nxt.ex = ci_r;
          dec_nxt.ey = cj_r + 11'd1;
        end else if (t <= fcum3_r) begin
          dec_nxt.ax = sgei_pkg::AXIS_K;
          dec_nxt.n0 = 32'(t - 36'd1 - fcum2_r);
          dec_nxt.ex = ci_r;
          dec_nxt.ey = cj_r;
        end else begin
          dec_nxt.st = sgei_pkg::ST_RANGE;
        end
      end
      sgei_pkg::KIND_EDGE_NUM: begin
        dec_nxt.is_pos = 1'b0;
        if (in_r.axis_in == sgei_pkg::AXIS_NONE ||
            (in_r.axis_in == sgei_pkg::AXIS_K && k_len_r == 11'd0)) begin
          dec_nxt.st = sgei_pkg::ST_AXIS;
        end else if (in_r.axis_in == sgei_pkg::AXIS_I) begin
          ei  = ci_r;
          eij = {1'b0, p_cij_r};
        end else if (in_r.axis_in == sgei_pkg::AXIS_J) begin
          ei          = i_len_r;
          eij         = {1'b0, p_icj_r};
          dec_nxt.off = e1_r;
        end else begin
          ei          = i_len_r;
          eij         = {1'b0, p_ij_r};
          dec_nxt.off = ecum2_r;
        end
      end
      sgei_pkg::KIND_FACE_NUM: begin
        dec_nxt.is_pos = 1'b0;
        if (in_r.axis_in == sgei_pkg::AXIS_I) begin
          ei  = ci_r + 11'd1;
          eij = {1'b0, p_c1c_r};
        end else if (in_r.axis_in == sgei_pkg::AXIS_J) begin
          ei          = ci_r;
          eij         = {1'b0, p_cc1_r};
          dec_nxt.off = f1_r;
        end else if (in_r.axis_in == sgei_pkg::AXIS_K) begin
          ei          = ci_r;
          eij         = {1'b0, p_cc_r};
          dec_nxt.off = fcum2_r;
        end else begin
          // axis none: plain cell number
          ei  = ci_r;
          eij = {1'b0, p_cc_r};
        end
      end
      default: dec_nxt.st = sgei_pkg::ST_NONE;
    endcase
    dec_nxt.m1 = in_r.pos_j * ei;
    dec_nxt.m2 = in_r.pos_k * eij;
  end

  always_ff @(posedge clk) begin
    if (en[1]) dec_r <= dec_nxt;
  end

  // Divide stages: n0 / ex in the first half, then quotient / ey.
  sgei_pkg::div_t seed;
  sgei_pkg::div_t dv_src [DIV_TOTAL];
  sgei_pkg::div_t dv_r   [DIV_TOTAL];

  always_comb begin
    logic [35:0] sum;
    sum = 36'd1 + 36'(dec_r.pi) + 36'(dec_r.m1) + 36'(dec_r.m2) + dec_r.off;
    seed        = '0;
    seed.is_pos = dec_r.is_pos;
    seed.st     = dec_r.st;
    seed.ax     = dec_r.ax;
    seed.nb     = sum[31:0] & NB_MASK;
    seed.ex     = dec_r.ex;
    seed.ey     = dec_r.ey;
    seed.x      = dec_r.n0;
    dv_src[0] = seed;
    for (int s = 1; s < DIV_TOTAL; s++) begin
      dv_src[s] = dv_r[s-1];
      if (s == sgei_pkg::DIV_STAGES) begin
        // hand over: keep i remainder, divide the quotient next
        dv_src[s].r0  = dv_r[s-1].rem[9:0];
        dv_src[s].rem = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_TOTAL; s++) begin
      if (en[DV0+s]) begin
        dv_r[s] <= sgei_pkg::div_steps(dv_src[s],
                     (s < sgei_pkg::DIV_STAGES) ? dv_src[s].ex : dv_src[s].ey);
      end
    end
  end

  // Output register: zero everything on error, drop the unused side.
  sgei_pkg::out_item_t out_nxt, out_r;

  always_comb begin
    sgei_pkg::div_t d;
    d = dv_r[DIV_TOTAL-1];
    out_nxt        = '0;
    out_nxt.status = d.st;
    if (d.st == sgei_pkg::ST_OK) begin
      if (d.is_pos) begin
        out_nxt.axis_out = d.ax;
        out_nxt.i_out    = d.r0;
        out_nxt.j_out    = d.rem[9:0];
        out_nxt.k_out    = d.x[9:0];
      end else begin
        out_nxt.number_out = d.nb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

[sv/sgei_checker.sv]
// Port-level checker for the grid indexer, bound to the top level.
`include "structured_grid_entity_indexer_unit_macros.svh"

module sgei_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sgei_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  logic is_err, num_zero, pos_zero, err_clean;

  assign is_err    = out_data.status != sgei_pkg::ST_OK;
  assign num_zero  = out_data.number_out == 32'd0;
  assign pos_zero  = out_data.axis_out == sgei_pkg::AXIS_NONE && out_data.i_out == 10'd0 &&
                     out_data.j_out == 10'd0 && out_data.k_out == 10'd0;
  assign err_clean = num_zero && pos_zero;

  `SGEI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SGEI_ASSERT_SAME(a_err_zero, out_valid && is_err, err_clean, "error result carries data")
  `SGEI_ASSERT_SAME(a_one_side, out_valid, num_zero || pos_zero, "number and position both set")
  `SGEI_ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, !in_ready, "request taken early")

endmodule

bind structured_grid_entity_indexer_unit sgei_checker u_sgei_checker (.*);
